[design/ffa_pkg.sv]
// shared constants, types and the size rounding function of the first-fit allocator
// no dependencies; compiled before every other file of the block
`default_nettype none

package ffa_pkg;

  // map geometry (both must be powers of two)
  localparam int UNIT_COUNT = 256;
  localparam int PAGE_UNITS = 32;

  localparam int UNIT_W  = $clog2(UNIT_COUNT);
  localparam int CNT_W   = UNIT_W + 1;
  localparam int SIZE_W  = 9;
  localparam int INDEX_W = 8;
  localparam int NEED_W  = SIZE_W + 1;
  localparam int CALC_W  = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;
  localparam int GRAIN   = 4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_MARK  = 1'b1;

  typedef enum logic [1:0] {
    MAP_FREE = 2'd0,
    MAP_USED = 2'd1,
    MAP_END  = 2'd2
  } map_code_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOROOM = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef struct packed {
    logic             func;
    logic [SIZE_W-1:0]  size;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic               vld;
    status_t            status;
    logic [INDEX_W-1:0] start;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [UNIT_W-1:0] rd_addr;
    logic              wr_en;
    logic [UNIT_W-1:0] wr_addr;
    logic [1:0]        wr_data;
  } map_req_t;

  // round up to the 4-unit grain, then to whole pages above half a page
  function automatic logic [NEED_W-1:0] round_alloc(input logic [SIZE_W-1:0] sz);
    logic [NEED_W-1:0] r;
    r = ({1'b0, sz} + NEED_W'(GRAIN - 1)) & ~NEED_W'(GRAIN - 1);
    if (r > NEED_W'(PAGE_UNITS / 2)) begin
      r = (r + NEED_W'(PAGE_UNITS - 1)) & ~NEED_W'(PAGE_UNITS - 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ffa_if.sv]
// valid/ready channel interfaces for requests and results of the allocator
// depends on ffa_pkg for the field widths
`default_nettype none

interface ffa_in_if;
  import ffa_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [SIZE_W-1:0]  size;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output func, output size, output index, input ready);
  modport sink   (input valid, input func, input size, input index, output ready);
endinterface

interface ffa_out_if;
  import ffa_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [INDEX_W-1:0] start_index;

  modport source (output valid, output status, output start_index, input ready);
  modport sink   (input valid, input status, input start_index, output ready);
endinterface

`default_nettype wire

[design/first_fit_unit_map_allocator_core.sv]
// top level of the first-fit unit map allocator: sequencer, map ram, result register
// depends on ffa_pkg, ffa_if, ffa_map_ram and ffa_seq
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      func, size, index
//   out_ch    out   valid / ready      status, start_index
//
// after reset the map ram is swept to free, one unit a cycle, with ready low throughout the sweep
// zero size, bad mark or oversize allocate: accept, response state, then the result register once it is free
// mark: one map write per unit in the write state, then the response state and the result register
// allocate: a scan with one ram read per unit (registered read data, checked one unit behind the reads)
//   then one write per granted unit and the response state; bounded by the single ram port pair
// a result waits in the output register; a new item is accepted meanwhile and stalls
//   only when its own result finds the register still full
`default_nettype none

module first_fit_unit_map_allocator_core (
  input  logic     clk,
  input  logic     rst_n,
  ffa_in_if.sink   in_ch,
  ffa_out_if.source out_ch
);
  import ffa_pkg::*;

  req_t     req;
  rsp_t     rsp;
  map_req_t map_req;
  logic     req_rdy;
  logic     slot_free;
  logic [1:0] map_rd_data;

  // output register
  logic               out_vld_r;
  logic [1:0]         out_status_r;
  logic [INDEX_W-1:0] out_start_r;

  assign req.func  = in_ch.func;
  assign req.size  = in_ch.size;
  assign req.index = in_ch.index;
  assign in_ch.ready = req_rdy;

  // result slot can take a new item when empty or being drained this cycle
  assign slot_free = !out_vld_r || out_ch.ready;

  ffa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld     (in_ch.valid),
    .req         (req),
    .req_rdy     (req_rdy),
    .rsp         (rsp),
    .rsp_take    (slot_free),
    .map_req     (map_req),
    .map_rd_data (map_rd_data)
  );

  // unit map: 2-bit code per allocation unit
  ffa_map_ram #(
    .DEPTH (UNIT_COUNT),
    .WIDTH (2)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_req.wr_en),
    .wr_addr (map_req.wr_addr),
    .wr_data (map_req.wr_data),
    .rd_en   (map_req.rd_en),
    .rd_addr (map_req.rd_addr),
    .rd_data (map_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rsp.vld && slot_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (rsp.vld && slot_free) begin
      out_status_r <= rsp.status;
      out_start_r  <= rsp.start;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.start_index = out_start_r;

endmodule

`default_nettype wire

[design/ffa_map_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no package dependencies
`default_nettype none

module ffa_map_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/ffa_seq.sv]
// request sequencer: map clear, first-fit scan and run write-back over the unit map ram
// depends on ffa_pkg
`default_nettype none

module ffa_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_vld,
  input  ffa_pkg::req_t    req,
  output logic             req_rdy,
  output ffa_pkg::rsp_t    rsp,
  input  logic             rsp_take,
  output ffa_pkg::map_req_t map_req,
  input  logic [1:0]       map_rd_data
);
  import ffa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [UNIT_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [UNIT_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [UNIT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [UNIT_W-1:0]  wr_last_r, wr_last_nxt;
  status_t            status_r, status_nxt;
  logic [INDEX_W-1:0] start_r, start_nxt;

  logic [NEED_W-1:0]  need_req;
  logic [CALC_W-1:0]  mark_end;
  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   run_start;

  always_comb begin
    need_req  = round_alloc(req.size);
    mark_end  = CALC_W'(req.index) + CALC_W'(req.size);
    run_inc   = (map_rd_data == MAP_FREE) ? run_r + CNT_W'(1) : '0;
    run_start = CNT_W'(pend_idx_r) + CNT_W'(1) - run_inc;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    scan_idx_nxt = scan_idx_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    run_nxt      = run_r;
    need_nxt     = need_r;
    wr_idx_nxt   = wr_idx_r;
    wr_last_nxt  = wr_last_r;
    status_nxt   = status_r;
    start_nxt    = start_r;
    req_rdy      = 1'b0;
    map_req      = '0;

    case (state_r)
      S_CLEAR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = clr_idx_r;
        map_req.wr_data = MAP_FREE;
        clr_idx_nxt     = clr_idx_r + UNIT_W'(1);
        if (clr_idx_r == UNIT_W'(UNIT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        req_rdy = 1'b1;
        if (req_vld) begin
          start_nxt = '0;
          if (req.size == '0) begin
            status_nxt = ST_BAD;
            state_nxt  = S_RESP;
          end else if (req.func == FUNC_ALLOC) begin
            need_nxt     = need_req;
            scan_idx_nxt = '0;
            run_nxt      = '0;
            if (CALC_W'(need_req) > CALC_W'(UNIT_COUNT)) begin
              status_nxt = ST_NOROOM;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (mark_end > CALC_W'(UNIT_COUNT)) begin
            status_nxt = ST_BAD;
            state_nxt  = S_RESP;
          end else begin
            wr_idx_nxt  = UNIT_W'(req.index);
            wr_last_nxt = UNIT_W'(mark_end - CALC_W'(1));
            start_nxt   = req.index;
            status_nxt  = ST_DONE;
            state_nxt   = S_WRITE;
          end
        end
      end
      S_SCAN: begin
        // reads run one unit ahead of the run check
        if (scan_idx_r < CNT_W'(UNIT_COUNT)) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = scan_idx_r[UNIT_W-1:0];
          scan_idx_nxt    = scan_idx_r + CNT_W'(1);
          pend_nxt        = 1'b1;
          pend_idx_nxt    = scan_idx_r[UNIT_W-1:0];
        end
        if (pend_r) begin
          run_nxt = run_inc;
          if (CALC_W'(run_inc) >= CALC_W'(need_r)) begin
            wr_idx_nxt  = run_start[UNIT_W-1:0];
            wr_last_nxt = pend_idx_r;
            start_nxt   = INDEX_W'(run_start);
            status_nxt  = ST_DONE;
            pend_nxt    = 1'b0;
            state_nxt   = S_WRITE;
          end else if (pend_idx_r == UNIT_W'(UNIT_COUNT - 1)) begin
            status_nxt = ST_NOROOM;
            pend_nxt   = 1'b0;
            state_nxt  = S_RESP;
          end
        end
      end
      S_WRITE: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = wr_idx_r;
        map_req.wr_data = (wr_idx_r == wr_last_r) ? MAP_END : MAP_USED;
        wr_idx_nxt      = wr_idx_r + UNIT_W'(1);
        if (wr_idx_r == wr_last_r) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.vld    = (state_r == S_RESP);
    rsp.status = status_r;
    rsp.start  = start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      pend_r    <= pend_nxt;
    end
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    run_r      <= run_nxt;
    need_r     <= need_nxt;
    wr_idx_r   <= wr_idx_nxt;
    wr_last_r  <= wr_last_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
  end

endmodule

`default_nettype wire

[sim/ffa_alloc_checker.sv]
// checker for the first-fit unit map allocator: watches both channels, keeps its own
// copy of the unit map, predicts each answer and compares it with the block's result
// depends on ffa_pkg and the channel interfaces of ffa_if
`default_nettype none

module ffa_alloc_checker (
  input  logic clk,
  input  logic rst_n,
  ffa_in_if    in_mon,
  ffa_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import ffa_pkg::*;

  typedef struct {
    status_t            st;
    logic [INDEX_W-1:0] first;
  } answer_t;

  map_code_t unit_state [UNIT_COUNT];
  answer_t   answer_q [$];
  int        errors = 0;

  // 4-unit grain, whole pages once above half a page
  function automatic int granted_length(input int sz);
    int len;
    len = ((sz + 3) / 4) * 4;
    if (len > PAGE_UNITS / 2) begin
      len = ((len + PAGE_UNITS - 1) / PAGE_UNITS) * PAGE_UNITS;
    end
    return len;
  endfunction

  function automatic void claim_units(input int base, input int len);
    for (int k = 0; k < len; k++) begin
      unit_state[base + k] = (k == len - 1) ? MAP_END : MAP_USED;
    end
  endfunction

  function automatic answer_t allocate_or_mark(input logic f, input int sz, input int ix);
    answer_t ans;
    int      need;
    int      free_run;
    ans.st    = ST_BAD;
    ans.first = '0;
    if (sz != 0) begin
      if (f == FUNC_ALLOC) begin
        need     = granted_length(sz);
        free_run = 0;
        ans.st   = ST_NOROOM;
        for (int u = 0; u < UNIT_COUNT; u++) begin
          free_run = (unit_state[u] == MAP_FREE) ? free_run + 1 : 0;
          if (free_run >= need) begin
            claim_units(u + 1 - free_run, free_run);
            ans.first = INDEX_W'(u + 1 - free_run);
            ans.st    = ST_DONE;
            break;
          end
        end
      end else if (ix + sz <= UNIT_COUNT) begin
        claim_units(ix, sz);
        ans.first = INDEX_W'(ix);
        ans.st    = ST_DONE;
      end
    end
    return ans;
  endfunction

  function automatic void flag(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      foreach (unit_state[u]) unit_state[u] = MAP_FREE;
      answer_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        answer_q.push_back(allocate_or_mark(in_mon.func, int'(in_mon.size),
                                            int'(in_mon.index)));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (answer_q.size() == 0) begin
          flag($sformatf("unexpected result: status %0d start %0d",
                         out_mon.status, out_mon.start_index));
        end else begin
          want = answer_q.pop_front();
          if (out_mon.status !== want.st || out_mon.start_index !== want.first) begin
            flag($sformatf("mismatch: status exp %0d got %0d, start exp %0d got %0d",
                           want.st, out_mon.status, want.first, out_mon.start_index));
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= answer_q.size();
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench top of the first-fit unit map allocator: clock, reset, request and
// result-side drivers, verdict; checking is done by ffa_alloc_checker
// depends on ffa_pkg, ffa_if, the allocator core and ffa_alloc_checker
`default_nettype none

module tb;
  import ffa_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  // slowest answer: full scan plus a full-map write, with margin
  localparam int DRAIN_CYCLES = 2 * UNIT_COUNT + 16;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   req_count = 0;
  bit   req_burst = 0;

  ffa_in_if  in_ch ();
  ffa_out_if out_ch ();

  first_fit_unit_map_allocator_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ffa_alloc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run (sweep, full scans, worst stalls)
  initial begin
    #30000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one request item; valid stays high across back-to-back items so it never
  // gets two assignments in one step
  task automatic send_req(input logic f, input int sz, input int ix);
    int gap;
    // every 32 items decide whether the next stretch runs without idle cycles
    if (req_count % 32 == 0) req_burst = ($urandom_range(0, 3) == 0);
    gap = req_burst ? 0 : $urandom_range(0, 18);
    req_count++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.size  <= SIZE_W'(sz);
    in_ch.index <= INDEX_W'(ix);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // allocate sizes lean small so the map fills slowly and fragments
  function automatic int alloc_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $urandom_range(1, 16);
    if (pick < 85) return $urandom_range(17, 64);
    if (pick < 97) return $urandom_range(65, 256);
    return $urandom_range(257, 511);  // rounds past the map size
  endfunction

  // mark sizes: mostly short, some up to the map end, some running past it
  function automatic int mark_size(input int ix);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 12);
    if (pick < 90) return $urandom_range(1, UNIT_COUNT - ix);
    return UNIT_COUNT - ix + $urandom_range(1, 8);
  endfunction

  // result side: a fresh stall for every item, with stretches of none at all
  initial begin : result_sink
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 0;
    forever begin
      if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 18);
      taken++;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int ix;
    int pick;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_ALLOC;
    in_ch.size  <= '0;
    in_ch.index <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero sizes on both functions
    send_req(FUNC_ALLOC, 0, 0);
    send_req(FUNC_MARK, 0, 255);
    // grain rounding, exactly half a page, just above half a page
    send_req(FUNC_ALLOC, 1, 77);
    send_req(FUNC_ALLOC, 16, 0);
    send_req(FUNC_ALLOC, 17, 255);
    send_req(FUNC_ALLOC, 3, 3);
    // marks at the top of the map, and ones that run past it
    send_req(FUNC_MARK, 1, 255);
    send_req(FUNC_MARK, 2, 255);
    send_req(FUNC_MARK, 7, 250);
    send_req(FUNC_MARK, 256, 1);
    // mark over a granted block, splitting it
    send_req(FUNC_MARK, 2, 0);
    // rounded size beyond the map, largest in-range size with no room left
    send_req(FUNC_ALLOC, 257, 0);
    send_req(FUNC_ALLOC, 511, 128);
    send_req(FUNC_ALLOC, 256, 0);
    // mark in free space, then allocate around it
    send_req(FUNC_MARK, 4, 96);
    send_req(FUNC_ALLOC, 24, 0);
    send_req(FUNC_ALLOC, 13, 0);
    // mark ending exactly at the last unit
    send_req(FUNC_MARK, 4, 252);
    send_req(FUNC_ALLOC, 48, 200);

    // random part
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      ix   = $urandom_range(0, UNIT_COUNT - 1);
      if (pick < 4) begin
        send_req(pick[0] ? FUNC_MARK : FUNC_ALLOC, 0, ix);
      end else if (pick < 70) begin
        send_req(FUNC_ALLOC, alloc_size(), ix);
      end else begin
        send_req(FUNC_MARK, mark_size(ix), ix);
      end
    end
    in_ch.valid <= 1'b0;

    // let every answer come back, then give the block time for anything stray
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/ffa_pkg.sv
design/ffa_if.sv
design/ffa_map_ram.sv
design/ffa_seq.sv
design/first_fit_unit_map_allocator_core.sv
sim/ffa_alloc_checker.sv
sim/tb.sv
